>>> design/semrgb_pkg.sv
// semrgb_pkg: shared types, widths and kernel tables for the rgb sobel edge unit
// no dependencies; used by every module of the unit but semrgb_ram
`default_nettype none

package semrgb_pkg;

  // frame geometry and history store
  localparam int MAX_WIDTH  = 1024;
  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 4;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W      = 16;
  localparam int XS_W       = COL_W + 2;
  localparam int YS_W       = ROW_W + 2;
  localparam int DS_W       = PTR_W + 2;

  // reset geometry
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // pixel and arithmetic widths
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int SUM_W      = 21;
  localparam int ROOT_STEPS = 8;
  localparam int TAPS       = 9;
  localparam int TAP_W      = $clog2(TAPS);

  localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
  localparam logic [PIX_W-1:0] SAT_VALUE = 8'd255;

  // configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_WIDTH_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_edge;
    logic [PIX_W-1:0] green_edge;
    logic [PIX_W-1:0] blue_edge;
    logic             frame_last;
  } out_item_t;

  // kernel weights, row-major over the 3x3 window
  typedef logic signed [2:0] coef_t;

  localparam coef_t GX_COEF [TAPS] = '{
    -3'sd1, 3'sd0, 3'sd1,
    -3'sd2, 3'sd0, 3'sd2,
    -3'sd1, 3'sd0, 3'sd1
  };

  localparam coef_t GY_COEF [TAPS] = '{
    -3'sd1, -3'sd2, -3'sd1,
     3'sd0,  3'sd0,  3'sd0,
     3'sd1,  3'sd2,  3'sd1
  };

  // commands from the sequencer to every colour lane
  typedef struct packed {
    logic                  clear;
    logic                  acc;
    coef_t                 coef_x;
    coef_t                 coef_y;
    logic                  square;
    logic                  sum;
    logic                  root_step;
    logic [ROOT_STEPS-1:0] root_bit;
    logic                  finish;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> design/semrgb_ram.sv
// semrgb_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module semrgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2052
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/semrgb_lane.sv
// semrgb_lane: one colour channel; gradient accumulation, squares and rounded root
// depends on semrgb_pkg
`default_nettype none

module semrgb_lane (
  input  wire logic                          clk,
  input  wire semrgb_pkg::lane_ctrl_t        ctrl,
  input  wire logic [semrgb_pkg::PIX_W-1:0]  pix,
  output logic      [semrgb_pkg::PIX_W-1:0]  result
);

  logic signed [semrgb_pkg::GRAD_W-1:0]   gx;
  logic signed [semrgb_pkg::GRAD_W-1:0]   gy;
  logic signed [semrgb_pkg::GRAD_W-1:0]   term_x;
  logic signed [semrgb_pkg::GRAD_W-1:0]   term_y;
  logic signed [2*semrgb_pkg::GRAD_W-1:0] prod_x;
  logic signed [2*semrgb_pkg::GRAD_W-1:0] prod_y;
  logic [semrgb_pkg::SQ_W-1:0]            sqx;
  logic [semrgb_pkg::SQ_W-1:0]            sqy;
  logic [semrgb_pkg::SUM_W-1:0]           mag_sq;
  logic [semrgb_pkg::PIX_W-1:0]           root;
  logic [semrgb_pkg::PIX_W-1:0]           trial;
  logic [2*semrgb_pkg::PIX_W-1:0]         trial_sq;
  logic [2*semrgb_pkg::PIX_W-1:0]         root_sq;
  logic [semrgb_pkg::SUM_W-1:0]           root_bound;
  logic [semrgb_pkg::PIX_W-1:0]           result_q;

  // pixel times a kernel weight of -2..2
  function automatic logic signed [semrgb_pkg::GRAD_W-1:0] weigh(
    input logic [semrgb_pkg::PIX_W-1:0] p,
    input semrgb_pkg::coef_t            c
  );
    logic signed [semrgb_pkg::GRAD_W-1:0] ext;
    ext = signed'(semrgb_pkg::GRAD_W'(p));
    unique case (c)
      3'sd1:   weigh = ext;
      3'sd2:   weigh = ext <<< 1;
      -3'sd1:  weigh = -ext;
      -3'sd2:  weigh = -(ext <<< 1);
      default: weigh = '0;
    endcase
  endfunction

  // weighted taps, squares and root trial
  always_comb begin
    term_x     = weigh(pix, ctrl.coef_x);
    term_y     = weigh(pix, ctrl.coef_y);
    prod_x     = gx * gx;
    prod_y     = gy * gy;
    trial      = root | ctrl.root_bit;
    trial_sq   = trial * trial;
    root_sq    = root * root;
    root_bound = semrgb_pkg::SUM_W'(root_sq) + semrgb_pkg::SUM_W'(root);
  end

  // gradient sums, one tap a cycle
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      gx <= '0;
      gy <= '0;
    end else if (ctrl.acc) begin
      gx <= gx + term_x;
      gy <= gy + term_y;
    end
  end

  // squared magnitude over two stages
  always_ff @(posedge clk) begin
    if (ctrl.square) begin
      sqx <= prod_x[semrgb_pkg::SQ_W-1:0];
      sqy <= prod_y[semrgb_pkg::SQ_W-1:0];
    end
    if (ctrl.sum) begin
      mag_sq <= semrgb_pkg::SUM_W'(sqx) + semrgb_pkg::SUM_W'(sqy);
    end
  end

  // bit-serial floor root, then round up past the half point or saturate
  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      root <= '0;
    end else if (ctrl.root_step) begin
      if (semrgb_pkg::SUM_W'(trial_sq) <= mag_sq) begin
        root <= trial;
      end
    end
    if (ctrl.finish) begin
      if (mag_sq > semrgb_pkg::SAT_LIMIT) begin
        result_q <= semrgb_pkg::SAT_VALUE;
      end else if (mag_sq > root_bound) begin
        result_q <= root + semrgb_pkg::PIX_W'(1);
      end else begin
        result_q <= root;
      end
    end
  end

  assign result = result_q;

endmodule

`default_nettype wire

>>> design/sobel_edge_magnitude_rgb_unit.sv
// sobel_edge_magnitude_rgb_unit: streaming 3x3 sobel edge magnitude on rgb pixels
// depends on semrgb_pkg, semrgb_ram, semrgb_lane
//
//   channel | signals                            | moves
//   pixels  | pix_valid pix_ready pix_data       | one pixel or flush tick a transfer
//   results | res_valid res_ready res_data       | one rgb edge result a transfer
//   config  | cfg_valid cfg_ready cfg_index/data | one register write a transfer
//
// a pixel that yields no result is taken while the block stays idle; an item that yields
// a result passes through accept, wrap steps, 9 window reads from the history ram,
// drain, square, sum, 8 root steps, rounding and the output load.
// synchronous reset; the history ram is not cleared and needs no clearing pass.
// a finished result waits in the output register while the next item is taken; a
// stalled output holds the output load, and a register write holds off pixels.
`default_nettype none

module sobel_edge_magnitude_rgb_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pix_valid,
  output logic                                     pix_ready,
  input  wire semrgb_pkg::in_item_t                pix_data,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output semrgb_pkg::out_item_t                    res_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [semrgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [semrgb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_READ, S_DRAIN, S_SQUARE, S_SUM, S_ROOT, S_FINISH, S_OUTPUT
  } state_t;

  state_t                                state;
  logic [semrgb_pkg::WID_W-1:0]          width;
  logic [semrgb_pkg::ROW_W-1:0]          height;
  logic [semrgb_pkg::COL_W-1:0]          col;
  logic [semrgb_pkg::ROW_W-1:0]          row;
  logic [semrgb_pkg::PEND_W-1:0]         pending;
  logic [semrgb_pkg::PTR_W-1:0]          wr_ptr;
  logic signed [semrgb_pkg::XS_W-1:0]    pos_x;
  logic signed [semrgb_pkg::YS_W-1:0]    pos_y;
  logic [semrgb_pkg::PEND_W-1:0]         res_age;
  logic [1:0]                            win_row;
  logic [1:0]                            win_col;
  logic [semrgb_pkg::ROOT_STEPS-1:0]     root_bit;
  logic                                  acc_pend;
  semrgb_pkg::coef_t                     cx_pend;
  semrgb_pkg::coef_t                     cy_pend;
  logic                                  tap_valid;

  logic                                  pix_fire;
  logic                                  cfg_fire;
  logic                                  is_pixel;
  logic [semrgb_pkg::WID_W-1:0]          col_plus;
  logic                                  col_wrap;
  logic [semrgb_pkg::COL_W-1:0]          col_next;
  logic [semrgb_pkg::ROW_W:0]            row_plus;
  logic [semrgb_pkg::ROW_W-1:0]          row_after;
  logic [semrgb_pkg::PEND_W-1:0]         pend_limit;
  logic                                  emit_px;
  logic [semrgb_pkg::PTR_W-1:0]          wr_ptr_next;
  logic [semrgb_pkg::COL_W-1:0]          start_col;
  logic [semrgb_pkg::XS_W-1:0]           back_u;
  logic signed [semrgb_pkg::XS_W-1:0]    start_x;
  logic signed [semrgb_pkg::YS_W-1:0]    start_y;
  logic [semrgb_pkg::PEND_W-1:0]         start_dist;
  logic signed [semrgb_pkg::XS_W-1:0]    width_x;
  logic signed [semrgb_pkg::YS_W-1:0]    height_y;
  logic signed [semrgb_pkg::DS_W-1:0]    width_d;
  logic signed [semrgb_pkg::YS_W-1:0]    ny;
  logic signed [semrgb_pkg::XS_W-1:0]    nx;
  logic signed [semrgb_pkg::DS_W-1:0]    row_off;
  logic signed [semrgb_pkg::DS_W-1:0]    tap_dist;
  logic signed [semrgb_pkg::DS_W-1:0]    addr_s;
  logic                                  tap_ok;
  logic [semrgb_pkg::TAP_W-1:0]          tap_idx;
  logic [semrgb_pkg::PTR_W-1:0]          rd_addr;
  logic [semrgb_pkg::RGB_W-1:0]          rd_data;
  logic [semrgb_pkg::RGB_W-1:0]          wr_data;
  logic [semrgb_pkg::CFG_WIDTH_W-1:0]    cfg_w;
  logic [semrgb_pkg::WID_W-1:0]          cfg_w_clamped;
  logic                                  frame_last;
  logic                                  out_free;
  semrgb_pkg::lane_ctrl_t                lane_ctrl;
  logic [semrgb_pkg::PIX_W-1:0]          lane_pix [3];
  logic [semrgb_pkg::PIX_W-1:0]          lane_res [3];

  // a register write takes priority over a pixel transfer in the same cycle
  assign pix_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign pix_fire  = pix_valid & pix_ready;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign is_pixel  = (pix_data.kind == semrgb_pkg::KIND_PIXEL);
  assign out_free  = !res_valid || res_ready;

  // raster position and history pointer after this pixel
  always_comb begin
    col_plus    = semrgb_pkg::WID_W'(col) + semrgb_pkg::WID_W'(1);
    col_wrap    = (col_plus >= width);
    col_next    = col_wrap ? '0 : col_plus[semrgb_pkg::COL_W-1:0];
    row_plus    = (semrgb_pkg::ROW_W + 1)'(row) + (semrgb_pkg::ROW_W + 1)'(1);
    if (!col_wrap) begin
      row_after = row;
    end else if (row_plus >= (semrgb_pkg::ROW_W + 1)'(height)) begin
      row_after = '0;
    end else begin
      row_after = row_plus[semrgb_pkg::ROW_W-1:0];
    end
    pend_limit  = semrgb_pkg::PEND_W'(width) + semrgb_pkg::PEND_W'(1);
    emit_px     = (pending >= pend_limit);
    wr_ptr_next = (wr_ptr == semrgb_pkg::PTR_W'(semrgb_pkg::HIST_DEPTH - 1)) ?
                  '0 : wr_ptr + semrgb_pkg::PTR_W'(1);
  end

  // position of the result pixel before wrapping, and its distance back in history
  always_comb begin
    if (is_pixel) begin
      start_col  = col_next;
      back_u     = semrgb_pkg::XS_W'(width) + semrgb_pkg::XS_W'(2);
      start_y    = signed'(semrgb_pkg::YS_W'(row_after));
      start_dist = pend_limit;
    end else begin
      start_col  = col;
      back_u     = semrgb_pkg::XS_W'(pending);
      start_y    = signed'(semrgb_pkg::YS_W'(row));
      start_dist = pending - semrgb_pkg::PEND_W'(1);
    end
    start_x = signed'(semrgb_pkg::XS_W'(start_col)) - signed'(back_u);
  end

  // window tap: bounds, age and history address
  always_comb begin
    width_x  = signed'(semrgb_pkg::XS_W'(width));
    height_y = signed'(semrgb_pkg::YS_W'(height));
    width_d  = signed'(semrgb_pkg::DS_W'(width));
    ny = pos_y + signed'(semrgb_pkg::YS_W'(win_row)) - signed'(semrgb_pkg::YS_W'(1));
    nx = pos_x + signed'(semrgb_pkg::XS_W'(win_col)) - signed'(semrgb_pkg::XS_W'(1));
    unique case (win_row)
      2'd0:    row_off = '0;
      2'd1:    row_off = width_d;
      default: row_off = width_d <<< 1;
    endcase
    tap_dist = signed'(semrgb_pkg::DS_W'(res_age)) + width_d + signed'(semrgb_pkg::DS_W'(1))
               - row_off - signed'(semrgb_pkg::DS_W'(win_col));
    tap_ok   = (ny >= 0) && (ny < height_y) && (nx >= 0) && (nx < width_x)
               && (tap_dist >= 0);
    addr_s   = signed'(semrgb_pkg::DS_W'(wr_ptr)) - signed'(semrgb_pkg::DS_W'(1)) - tap_dist;
    if (addr_s < 0) begin
      addr_s = addr_s + signed'(semrgb_pkg::DS_W'(semrgb_pkg::HIST_DEPTH));
    end
    rd_addr  = addr_s[semrgb_pkg::PTR_W-1:0];
    tap_idx  = semrgb_pkg::TAP_W'(win_row) * semrgb_pkg::TAP_W'(3)
               + semrgb_pkg::TAP_W'(win_col);
  end

  // width register write with clamping
  always_comb begin
    cfg_w = cfg_data[semrgb_pkg::CFG_WIDTH_W-1:0];
    if (cfg_w == '0) begin
      cfg_w_clamped = semrgb_pkg::WID_W'(1);
    end else if (int'(cfg_w) > semrgb_pkg::MAX_WIDTH) begin
      cfg_w_clamped = semrgb_pkg::WID_W'(semrgb_pkg::MAX_WIDTH);
    end else begin
      cfg_w_clamped = semrgb_pkg::WID_W'(cfg_w);
    end
  end

  assign frame_last = (pos_y == height_y - signed'(semrgb_pkg::YS_W'(1))) &&
                      (pos_x == width_x - signed'(semrgb_pkg::XS_W'(1)));

  // history of incoming pixels
  assign wr_data = {pix_data.red_in, pix_data.green_in, pix_data.blue_in};

  semrgb_ram #(
    .WIDTH (semrgb_pkg::RGB_W),
    .DEPTH (semrgb_pkg::HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (pix_fire && is_pixel),
    .wr_addr (wr_ptr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // lane commands
  always_comb begin
    lane_ctrl.clear     = (state == S_WRAP);
    lane_ctrl.acc       = acc_pend;
    lane_ctrl.coef_x    = cx_pend;
    lane_ctrl.coef_y    = cy_pend;
    lane_ctrl.square    = (state == S_SQUARE);
    lane_ctrl.sum       = (state == S_SUM);
    lane_ctrl.root_step = (state == S_ROOT);
    lane_ctrl.root_bit  = root_bit;
    lane_ctrl.finish    = (state == S_FINISH);
  end

  // one lane per colour channel, red in the top byte
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    assign lane_pix[ch] = tap_valid ?
                          rd_data[semrgb_pkg::PIX_W*(2-ch) +: semrgb_pkg::PIX_W] : '0;
    semrgb_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .pix    (lane_pix[ch]),
      .result (lane_res[ch])
    );
  end

  // sequencer, frame counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      width     <= semrgb_pkg::WID_W'(semrgb_pkg::RESET_WIDTH);
      height    <= semrgb_pkg::ROW_W'(semrgb_pkg::RESET_HEIGHT);
      col       <= '0;
      row       <= '0;
      pending   <= '0;
      wr_ptr    <= '0;
      acc_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      acc_pend  <= (state == S_READ);
      cx_pend   <= semrgb_pkg::GX_COEF[tap_idx];
      cy_pend   <= semrgb_pkg::GY_COEF[tap_idx];
      tap_valid <= tap_ok;

      // output register: a new result may replace one leaving in the same cycle
      if (state == S_OUTPUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pix_fire) begin
            if (is_pixel) begin
              wr_ptr <= wr_ptr_next;
              col    <= col_next;
              row    <= row_after;
              if (emit_px) begin
                pos_x   <= start_x;
                pos_y   <= start_y;
                res_age <= start_dist;
                state   <= S_WRAP;
              end else begin
                pending <= pending + semrgb_pkg::PEND_W'(1);
              end
            end else if (pending != '0) begin
              pos_x   <= start_x;
              pos_y   <= start_y;
              res_age <= start_dist;
              pending <= pending - semrgb_pkg::PEND_W'(1);
              state   <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          // bring the result position back into the frame
          if (pos_x < 0) begin
            pos_x <= pos_x + width_x;
            pos_y <= pos_y - signed'(semrgb_pkg::YS_W'(1));
          end else if (pos_y < 0) begin
            pos_y <= pos_y + height_y;
          end else begin
            win_row <= '0;
            win_col <= '0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          if (win_col == 2'd2) begin
            win_col <= '0;
            win_row <= win_row + 2'd1;
            if (win_row == 2'd2) begin
              state <= S_DRAIN;
            end
          end else begin
            win_col <= win_col + 2'd1;
          end
        end
        S_DRAIN: begin
          state <= S_SQUARE;
        end
        S_SQUARE: begin
          state <= S_SUM;
        end
        S_SUM: begin
          root_bit <= {1'b1, {(semrgb_pkg::ROOT_STEPS-1){1'b0}}};
          state    <= S_ROOT;
        end
        S_ROOT: begin
          root_bit <= root_bit >> 1;
          if (root_bit[0]) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_OUTPUT;
        end
        S_OUTPUT: begin
          if (out_free) begin
            res_data.red_edge   <= lane_res[0];
            res_data.green_edge <= lane_res[1];
            res_data.blue_edge  <= lane_res[2];
            res_data.frame_last <= frame_last;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // register writes restart the frame and drop pending results
      if (cfg_fire) begin
        unique case (semrgb_pkg::cfg_reg_t'(cfg_index))
          semrgb_pkg::REG_IMAGE_WIDTH: begin
            width <= cfg_w_clamped;
          end
          semrgb_pkg::REG_IMAGE_HEIGHT: begin
            height <= (cfg_data == '0) ? semrgb_pkg::ROW_W'(1) : cfg_data;
          end
          default: begin
            width <= width;
          end
        endcase
        col     <= '0;
        row     <= '0;
        pending <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/semrgb_checker.sv
// semrgb_checker: port-level assertions for the rgb sobel edge unit, with its bind
// depends on semrgb_pkg and sobel_edge_magnitude_rgb_unit
`default_nettype none

module semrgb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              pix_valid,
  input wire logic                              pix_ready,
  input wire logic                              res_valid,
  input wire logic                              res_ready,
  input wire semrgb_pkg::out_item_t             res_data,
  input wire logic                              cfg_valid
);

  // a stalled result holds its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // a new result appears only as the unit returns to taking pixels
  a_res_rise_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> pix_ready || cfg_valid)
    else $error("result raised while pixel channel busy");

  // a new result follows a cycle of busy processing, never a direct transfer
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(pix_ready) && !$past(pix_valid && pix_ready))
    else $error("result raised without processing");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_rgb_unit semrgb_checker u_checker (.*);

`default_nettype wire

>>> tb/sobel_edge_magnitude_rgb_unit_tb.sv
// sobel_edge_magnitude_rgb_unit_tb: self-checking bench for the rgb sobel edge unit
// depends on semrgb_pkg and sobel_edge_magnitude_rgb_unit; the predictor is kept in here
`default_nettype none

module sobel_edge_magnitude_rgb_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 2 * semrgb_pkg::MAX_WIDTH + 4;
  localparam int ITEM_TARGET = 1850;
  localparam int SETTLE_CYCLES = 60;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_ready;
  semrgb_pkg::in_item_t pix_data;
  logic res_valid;
  logic res_ready;
  semrgb_pkg::out_item_t res_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [semrgb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [semrgb_pkg::CFG_DATA_W-1:0] cfg_data;

  sobel_edge_magnitude_rgb_unit dut (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: pixel history, frame position and geometry
  logic [semrgb_pkg::RGB_W-1:0] pixel_history [STORE_DEPTH];
  int wr_slot;
  int col_pos;
  int row_pos;
  int pend_cnt;
  int frame_width;
  int frame_height;
  semrgb_pkg::out_item_t edge_queue [$];

  int items_sent;
  int results_seen;
  int flushes_sent;
  int frame_ends_seen;
  int mismatches;
  int cfg_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout with %0d results still expected", edge_queue.size());
    $display("sobel_edge_magnitude_rgb_unit_tb NOT OK");
    $finish;
  end

  // rounded root of the squared gradient, saturated
  function automatic logic [semrgb_pkg::PIX_W-1:0] edge_mag(int gx, int gy);
    int unsigned s;
    int unsigned r;
    int unsigned t;
    s = gx * gx + gy * gy;
    r = 0;
    if (s > 65280) return 8'd255;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= s) r = t;
    end
    if (s > r * r + r) r++;
    if (r > 255) r = 255;
    return r[semrgb_pkg::PIX_W-1:0];
  endfunction

  // edge result for the pixel age items before the newest one
  task automatic queue_edge(int age, int back);
    int x;
    int y;
    int ny;
    int nx;
    int d;
    int s;
    int gx;
    int gy;
    int p [9];
    logic [semrgb_pkg::RGB_W-1:0] win [9];
    logic [semrgb_pkg::PIX_W-1:0] mag [3];
    semrgb_pkg::out_item_t res;
    x = col_pos - back;
    y = row_pos;
    for (int i = 0; i < 4; i++) if (x < 0) begin
      x += frame_width;
      y--;
    end
    for (int i = 0; i < 4; i++) if (y < 0) y += frame_height;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        ny = y + dy;
        nx = x + dx;
        d = age - dy * frame_width - dx;
        win[(dy + 1) * 3 + dx + 1] = '0;
        if (ny >= 0 && ny < frame_height && nx >= 0 && nx < frame_width && d >= 0) begin
          s = wr_slot - 1 - d;
          if (s < 0) s += STORE_DEPTH;
          win[(dy + 1) * 3 + dx + 1] = pixel_history[s];
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) p[i] = int'((win[i] >> (16 - 8 * ch)) & 24'hFF);
      gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
      gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
      mag[ch] = edge_mag(gx, gy);
    end
    res.red_edge = mag[0];
    res.green_edge = mag[1];
    res.blue_edge = mag[2];
    res.frame_last = (y == frame_height - 1 && x == frame_width - 1);
    edge_queue.push_back(res);
  endtask

  // advance the predictor by one accepted item
  task automatic predict_item(semrgb_pkg::in_item_t it);
    if (it.kind == semrgb_pkg::KIND_PIXEL) begin
      pixel_history[wr_slot] = {it.red_in, it.green_in, it.blue_in};
      wr_slot = (wr_slot + 1 >= STORE_DEPTH) ? 0 : wr_slot + 1;
      col_pos++;
      if (col_pos >= frame_width) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= frame_height) row_pos = 0;
      end
      if (pend_cnt >= frame_width + 1) queue_edge(frame_width + 1, frame_width + 2);
      else pend_cnt++;
    end else begin
      flushes_sent++;
      if (pend_cnt != 0) begin
        queue_edge(pend_cnt - 1, pend_cnt);
        pend_cnt--;
      end
    end
  endtask

  // send one item; valid stays high afterwards until a gap lowers it
  task automatic send_item(semrgb_pkg::in_item_t it);
    @(negedge clk);
    pix_valid <= 1'b1;
    pix_data <= it;
    do @(posedge clk); while (!pix_ready);
    predict_item(it);
    items_sent++;
  endtask

  task automatic send_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      pix_valid <= 1'b0;
    end
  endtask

  function automatic semrgb_pkg::in_item_t rand_pixel();
    semrgb_pkg::in_item_t it;
    it.kind = semrgb_pkg::KIND_PIXEL;
    it.red_in = 8'($urandom);
    it.green_in = 8'($urandom);
    it.blue_in = 8'($urandom);
    return it;
  endfunction

  function automatic semrgb_pkg::in_item_t flush_item();
    semrgb_pkg::in_item_t it;
    it = '0;
    it.kind = semrgb_pkg::KIND_FLUSH;
    it.red_in = 8'($urandom);
    it.green_in = 8'($urandom);
    it.blue_in = 8'($urandom);
    return it;
  endfunction

  // burst-shaped sender
  int burst_left;
  task automatic send_paced(semrgb_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) send_gap($urandom_range(1, 6));
    end
    burst_left--;
    send_item(it);
  endtask

  // wait until every expected result has come, then let the block settle
  task automatic drain_all();
    send_gap(1);
    while (edge_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write on an idle block
  task automatic write_reg(semrgb_pkg::cfg_reg_t idx,
                           logic [semrgb_pkg::CFG_DATA_W-1:0] value);
    int v;
    drain_all();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == semrgb_pkg::REG_IMAGE_WIDTH) begin
      v = int'(value & 16'h07FF);
      if (v == 0) v = 1;
      if (v > semrgb_pkg::MAX_WIDTH) v = semrgb_pkg::MAX_WIDTH;
      frame_width = v;
    end else begin
      v = int'(value);
      if (v == 0) v = 1;
      frame_height = v;
    end
    col_pos = 0;
    row_pos = 0;
    pend_cnt = 0;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [semrgb_pkg::CFG_DATA_W-1:0] w,
                              logic [semrgb_pkg::CFG_DATA_W-1:0] h);
    write_reg(semrgb_pkg::REG_IMAGE_WIDTH, w);
    write_reg(semrgb_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // receiver stall pattern: modes of random length
  initial begin
    int mode;
    int left;
    res_ready = 1'b0;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(30, 300);
      end
      left--;
      case (mode)
        0: res_ready <= 1'b1;
        1: res_ready <= ($urandom_range(0, 1) == 1);
        2: res_ready <= ($urandom_range(0, 9) < 8);
        default: res_ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    semrgb_pkg::out_item_t exp_res;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (res_data.frame_last) frame_ends_seen++;
      if (edge_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_data);
      end else begin
        exp_res = edge_queue.pop_front();
        if (res_data.red_edge !== exp_res.red_edge ||
            res_data.green_edge !== exp_res.green_edge ||
            res_data.blue_edge !== exp_res.blue_edge ||
            res_data.frame_last !== exp_res.frame_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected r%0d g%0d b%0d last%0b, got r%0d g%0d b%0d last%0b",
                     results_seen, exp_res.red_edge, exp_res.green_edge, exp_res.blue_edge,
                     exp_res.frame_last, res_data.red_edge, res_data.green_edge,
                     res_data.blue_edge, res_data.frame_last);
        end
      end
    end
  end

  // corners, flat and full-scale pixels on a 3x3 frame, idle flush, degenerate geometry
  task automatic test_small_frame();
    semrgb_pkg::in_item_t it;
    send_item(flush_item());
    set_geometry(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) begin
      it.kind = semrgb_pkg::KIND_PIXEL;
      it.red_in = (i % 2) ? 8'hFF : 8'h00;
      it.green_in = (i < 3) ? 8'hFF : 8'h00;
      it.blue_in = (i == 4) ? 8'hFF : 8'h00;
      send_item(it);
    end
    for (int i = 0; i < 5; i++) send_item(flush_item());
    set_geometry(16'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_item(rand_pixel());
    for (int i = 0; i < 3; i++) send_item(flush_item());
  endtask

  // width above the limit acts as the limit; tallest frame
  task automatic test_widest_row();
    set_geometry(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < semrgb_pkg::MAX_WIDTH + 4; i++) send_paced(rand_pixel());
    send_item(flush_item());
    set_geometry(16'hF805, 16'd2);
    for (int i = 0; i < 12; i++) send_item(rand_pixel());
    drain_all();
  endtask

  // back-to-back frames with random geometry, flush noise and partial frames
  task automatic test_random_frames();
    int w;
    int h;
    int n;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: w = 1;
        1: w = $urandom_range(2, 3);
        default: w = $urandom_range(1, 16);
      endcase
      h = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 6);
      set_geometry(16'(w), 16'(h));
      n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
      // tall frames are only ever partly sent
      if (n > 120) n = $urandom_range(w + 2, 120);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) send_paced(flush_item());
        else send_paced(rand_pixel());
        // hold off once mid-stream until the block has caught up
        if (i == n / 2 && $urandom_range(0, 3) == 0) drain_all();
      end
      n = $urandom_range(0, w + 3);
      for (int i = 0; i < n; i++) send_paced(flush_item());
    end
    set_geometry(16'(semrgb_pkg::RESET_WIDTH), 16'(semrgb_pkg::RESET_HEIGHT));
  endtask

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0;
    pix_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_width = semrgb_pkg::RESET_WIDTH;
    frame_height = semrgb_pkg::RESET_HEIGHT;
    wr_slot = 0;
    col_pos = 0;
    row_pos = 0;
    pend_cnt = 0;
    burst_left = 0;
    items_sent = 0;
    results_seen = 0;
    flushes_sent = 0;
    frame_ends_seen = 0;
    mismatches = 0;
    cfg_writes = 0;
    for (int i = 0; i < STORE_DEPTH; i++) pixel_history[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_small_frame();
    test_widest_row();
    test_random_frames();
    drain_all();

    if (edge_queue.size() != 0) mismatches++;
    $display("covered %0d items (%0d flush), %0d results, %0d frame ends, %0d register writes",
             items_sent, flushes_sent, results_seen, frame_ends_seen, cfg_writes);
    $display("%0d mismatching or unmatched results", mismatches);
    if (mismatches == 0) begin
      $display("sobel_edge_magnitude_rgb_unit_tb OK");
    end else begin
      $display("sobel_edge_magnitude_rgb_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/semrgb_pkg.sv
design/semrgb_ram.sv
design/semrgb_lane.sv
design/sobel_edge_magnitude_rgb_unit.sv
design/semrgb_checker.sv
tb/sobel_edge_magnitude_rgb_unit_tb.sv
